@@ rtl/rgbnv12_pkg.sv @@
`default_nettype none

package rgbnv12_pkg;

  // Frame geometry limits and register reset values
  localparam logic [12:0] MaxWidth     = 13'd4096;
  localparam logic [12:0] MaxHeight    = 13'd4096;
  localparam logic [12:0] WidthReset   = 13'd640;
  localparam logic [12:0] HeightReset  = 13'd480;

  // Configuration port
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 13;
  localparam logic [CfgIndexWidth-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgFrameHeight = 2'd1;

  // One RGB pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // One converted pixel
  typedef struct packed {
    logic [7:0]  luma;
    logic [23:0] luma_index;
    logic        chroma_valid;
    logic [7:0]  chroma_u;
    logic [7:0]  chroma_v;
    logic [24:0] chroma_index;
    logic        frame_last;
  } res_t;

  // Raster position of one pixel, captured with it
  typedef struct packed {
    logic        chroma_valid;
    logic        frame_last;
    logic [23:0] luma_index;
    logic [23:0] chroma_off;
  } pos_t;

endpackage

`default_nettype wire

@@ rtl/rgbnv12_frame_pos.sv @@
`default_nettype none

module rgbnv12_frame_pos (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [rgbnv12_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  wire logic [rgbnv12_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  wire logic                                    advance_i,
  output rgbnv12_pkg::pos_t                            pos_o,
  output logic [24:0]                                  frame_area_o
);

  logic [12:0] width_q, width_d;
  logic [12:0] height_q, height_d;
  logic [11:0] col_q, col_d;
  logic [11:0] row_q, row_d;
  logic [23:0] luma_q, luma_d;
  logic [23:0] row_base_q, row_base_d;
  logic [24:0] area_q;
  logic [25:0] area_full;
  logic [12:0] w_eff, h_eff;
  logic        last_col, last_row, frame_last, cfg_hit;

  // Clamp a dimension register to 2..max and force it even
  function automatic logic [12:0] eff_dim(input logic [12:0] r, input logic [12:0] maxv);
    logic [12:0] d;
    d = r;
    if (d < 13'd2) d = 13'd2;
    if (d > maxv) d = maxv;
    d[0] = 1'b0;
    return d;
  endfunction

  assign w_eff = eff_dim(width_q, rgbnv12_pkg::MaxWidth);
  assign h_eff = eff_dim(height_q, rgbnv12_pkg::MaxHeight);

  // Detect line and frame ends
  assign last_col   = (13'({1'b0, col_q}) + 13'd1) >= w_eff;
  assign last_row   = (13'({1'b0, row_q}) + 13'd1) >= h_eff;
  assign frame_last = last_col && last_row;

  // Decode register writes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        rgbnv12_pkg::CfgFrameWidth: begin
          width_d = cfg_data_i;
          cfg_hit = 1'b1;
        end
        rgbnv12_pkg::CfgFrameHeight: begin
          height_d = cfg_data_i;
          cfg_hit  = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Advance the raster counters, restart the frame on a register write
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    luma_d     = luma_q;
    row_base_d = row_base_q;
    if (cfg_hit) begin
      col_d      = '0;
      row_d      = '0;
      luma_d     = '0;
      row_base_d = '0;
    end else if (advance_i) begin
      if (frame_last) begin
        col_d      = '0;
        row_d      = '0;
        luma_d     = '0;
        row_base_d = '0;
      end else begin
        luma_d = luma_q + 24'd1;
        if (last_col) begin
          col_d = '0;
          row_d = row_q + 12'd1;
          if (row_q[0]) begin
            row_base_d = row_base_q + 24'(w_eff);
          end
        end else begin
          col_d = col_q + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= rgbnv12_pkg::WidthReset;
      height_q   <= rgbnv12_pkg::HeightReset;
      col_q      <= '0;
      row_q      <= '0;
      luma_q     <= '0;
      row_base_q <= '0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      col_q      <= col_d;
      row_q      <= row_d;
      luma_q     <= luma_d;
      row_base_q <= row_base_d;
    end
  end

  // Luma plane size, the base of the chroma plane
  assign area_full = 26'(w_eff) * 26'(h_eff);

  always_ff @(posedge clk_i) begin
    area_q <= area_full[24:0];
  end

  assign frame_area_o        = area_q;
  assign pos_o.chroma_valid  = !col_q[0] && !row_q[0];
  assign pos_o.frame_last    = frame_last;
  assign pos_o.luma_index    = luma_q;
  assign pos_o.chroma_off    = row_base_q + 24'(col_q);

  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    13'({1'b0, col_q}) < w_eff)
    else $error("column counter beyond line width");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    13'({1'b0, row_q}) < h_eff)
    else $error("row counter beyond frame height");

  a_luma_tracks_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    luma_q == 24'(32'(row_q) * 32'(w_eff) + 32'(col_q)))
    else $error("luma index out of step with row and column");

endmodule

`default_nettype wire

@@ rtl/rgbnv12_convert.sv @@
`default_nettype none

module rgbnv12_convert (
  input  wire rgbnv12_pkg::pix_t  pix_i,
  input  wire rgbnv12_pkg::pos_t  pos_i,
  input  wire logic [24:0]        frame_area_i,
  output rgbnv12_pkg::res_t       res_o
);

  logic signed [17:0] r_s, g_s, b_s;
  logic signed [17:0] y_sum, u_sum, v_sum;
  logic [7:0]         u_val, v_val;

  // Floor divide by 256, add offset, clamp to 0..255
  function automatic logic [7:0] shift_clamp(input logic signed [17:0] x,
                                             input logic signed [10:0] off);
    logic signed [10:0] s;
    s = 11'($signed(x[17:8])) + off;
    if (s < 11'sd0) return 8'd0;
    if (s > 11'sd255) return 8'd255;
    return s[7:0];
  endfunction

  assign r_s = $signed({10'd0, pix_i.red});
  assign g_s = $signed({10'd0, pix_i.green});
  assign b_s = $signed({10'd0, pix_i.blue});

  // BT.601 weighted sums
  assign y_sum = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s;
  assign u_sum = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s;
  assign v_sum = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s;

  assign u_val = shift_clamp(u_sum, 11'sd128);
  assign v_val = shift_clamp(v_sum, 11'sd128);

  // Chroma fields are zero off the 2x2 top-left sample
  assign res_o.luma         = shift_clamp(y_sum, 11'sd16);
  assign res_o.luma_index   = pos_i.luma_index;
  assign res_o.chroma_valid = pos_i.chroma_valid;
  assign res_o.chroma_u     = pos_i.chroma_valid ? u_val : 8'd0;
  assign res_o.chroma_v     = pos_i.chroma_valid ? v_val : 8'd0;
  assign res_o.chroma_index = pos_i.chroma_valid ?
                              frame_area_i + 25'(pos_i.chroma_off) : 25'd0;
  assign res_o.frame_last   = pos_i.frame_last;

endmodule

`default_nettype wire

@@ rtl/rgb_to_nv12_stream_converter_top.sv @@
// RGB to NV12 stream converter, BT.601 studio range.
// Input channel: one RGB pixel per item in raster order (in_valid_i, in_stall_o,
// in_data_i). Output channel: one result item per pixel (out_valid_o,
// out_stall_i, out_data_o) with luma, its Y plane index and, on even row and
// even column, U, V and the NV12 byte index of U (V follows at index plus one).
// An item is taken when valid is high and stall is low.
// Each item passes an input register, then the color math and index add into
// the result register; it waits in the input register while the result
// register is full and the receiver stalls.
// Throughput is one pixel per clock while the receiver does not stall; the
// two stage registers let a new pixel enter while a finished result waits
// to be taken. When the receiver stalls, the result register holds, the input
// register fills, and in_stall_o rises once both are full.
// Reset sets width 640, height 480 and puts the raster position at the frame
// start. Writing frame_width or frame_height via cfg_we_i also restarts the
// frame; write only while no item is in flight. The chroma plane base is the
// width times height, registered again after the width and height registers.
`default_nettype none

module rgb_to_nv12_stream_converter_top (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [rgbnv12_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  wire logic [rgbnv12_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire rgbnv12_pkg::pix_t                       in_data_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output rgbnv12_pkg::res_t                            out_data_o
);

  logic               in_valid_q, in_valid_d;
  rgbnv12_pkg::pix_t  in_pix_q;
  rgbnv12_pkg::pos_t  in_pos_q;
  logic               out_valid_q, out_valid_d;
  rgbnv12_pkg::res_t  out_data_q;
  rgbnv12_pkg::pos_t  pos;
  rgbnv12_pkg::res_t  res;
  logic [24:0]        frame_area;
  logic               out_ready, in_ready, in_acc, stage_adv;

  // Stage handshake
  assign out_ready = !out_valid_q || !out_stall_i;
  assign stage_adv = in_valid_q && out_ready;
  assign in_ready  = !in_valid_q || out_ready;
  assign in_acc    = in_valid_i && in_ready;

  // Track raster position and configuration
  rgbnv12_frame_pos u_frame_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .advance_i    (in_acc),
    .pos_o        (pos),
    .frame_area_o (frame_area)
  );

  // Convert the registered pixel
  rgbnv12_convert u_convert (
    .pix_i        (in_pix_q),
    .pos_i        (in_pos_q),
    .frame_area_i (frame_area),
    .res_o        (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (stage_adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_ready ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item and its position
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_pix_q <= in_data_i;
      in_pos_q <= pos;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (stage_adv) begin
      out_data_q <= res;
    end
  end

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled while result register is empty");

  a_odd_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.chroma_valid |->
      out_data_o.chroma_u == 8'd0 && out_data_o.chroma_v == 8'd0 &&
      out_data_o.chroma_index == 25'd0)
    else $error("chroma fields set on a pixel without chroma");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_adv && in_pos_q.frame_last |=> !in_valid_q ||
      (in_pos_q.luma_index == 24'd0 && in_pos_q.chroma_valid))
    else $error("pixel after frame end not at frame start");

endmodule

`default_nettype wire
